// File: sv/tcch_pkg.sv
`default_nettype none
package tcch_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int NSTEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int ANG_W = 32;
    localparam int CS_W = 34;
    localparam int VEC_W = 56;
    localparam logic signed [ANG_W-1:0] HALF_TURN_ANG = 32'sd1179648000;
    localparam logic signed [CS_W-1:0] CORDIC_START = 34'sd652032874;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [CS_W-1:0] cs_t;
    typedef logic signed [VEC_W-1:0] vec_t;

    typedef struct packed {
        cs_t x;
        cs_t y;
        ang_t z;
        logic flip;
    } rot_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
        logic zero;
    } vecs_t;

    function automatic ang_t atan_entry(input int i);
        case (i)
            0: atan_entry = 32'sd294912000;
            1: atan_entry = 32'sd174096719;
            2: atan_entry = 32'sd91987925;
            3: atan_entry = 32'sd46694507;
            4: atan_entry = 32'sd23437865;
            5: atan_entry = 32'sd11730358;
            6: atan_entry = 32'sd5866610;
            7: atan_entry = 32'sd2933484;
            8: atan_entry = 32'sd1466765;
            9: atan_entry = 32'sd733385;
            10: atan_entry = 32'sd366693;
            11: atan_entry = 32'sd183347;
            12: atan_entry = 32'sd91673;
            13: atan_entry = 32'sd45837;
            14: atan_entry = 32'sd22918;
            15: atan_entry = 32'sd11459;
            16: atan_entry = 32'sd5730;
            17: atan_entry = 32'sd2865;
            18: atan_entry = 32'sd1432;
            19: atan_entry = 32'sd716;
            20: atan_entry = 32'sd358;
            21: atan_entry = 32'sd179;
            22: atan_entry = 32'sd90;
            23: atan_entry = 32'sd45;
            default: atan_entry = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: sv/tcch_rot_cell.sv
`default_nettype none
module tcch_rot_cell (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [4:0]      idx,
    input  wire tcch_pkg::rot_t  a_in,
    input  wire tcch_pkg::rot_t  b_in,
    output tcch_pkg::rot_t       a_out,
    output tcch_pkg::rot_t       b_out
);
    import tcch_pkg::*;

    rot_t a_next, b_next;
    rot_t a_reg, b_reg;

    function automatic rot_t step(input rot_t v, input logic [4:0] i);
        rot_t r;
        cs_t dx, dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        r = v;
        if (!v.z[ANG_W-1]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - atan_entry(int'(i));
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + atan_entry(int'(i));
        end
        return r;
    endfunction

    always_comb begin
        a_next = step(a_in, idx);
        b_next = step(b_in, idx);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;
endmodule
`default_nettype wire

// File: sv/tcch_vec_cell.sv
`default_nettype none
module tcch_vec_cell (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [4:0]      idx,
    input  wire tcch_pkg::vecs_t v_in,
    input  wire tcch_pkg::ang_t  dec_in,
    output tcch_pkg::vecs_t      v_out,
    output tcch_pkg::ang_t       dec_out
);
    import tcch_pkg::*;

    vecs_t v_next, v_reg;
    ang_t dec_reg;

    always_comb begin
        vec_t dx, dy;
        dx = v_in.y >>> idx;
        dy = v_in.x >>> idx;
        v_next = v_in;
        if (v_in.y[VEC_W-1]) begin
            v_next.x = v_in.x - dx;
            v_next.y = v_in.y + dy;
            v_next.z = v_in.z - atan_entry(int'(idx));
        end else begin
            v_next.x = v_in.x + dx;
            v_next.y = v_in.y - dy;
            v_next.z = v_in.z + atan_entry(int'(idx));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
            dec_reg <= dec_in;
        end
    end

    assign v_out = v_reg;
    assign dec_out = dec_reg;
endmodule
`default_nettype wire

// File: sv/tilt_compensated_compass_heading_top.sv
// Tilt-compensated heading: one item per cycle in, one heading per item out, in order.
// The pipe is two CORDIC cell rows of NSTEPS stages each, plus angle reduction, two
// multiply stages, sum, fold and wrap. The whole pipe advances when the output register
// is empty or being taken, so s_axis_tready drops only while m_axis_tvalid is held.
// Declination is captured with each item at entry.
`default_nettype none
module tilt_compensated_compass_heading_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output wire logic        s_axis_tready,
    // mag_x[15:0], mag_y[31:16], mag_z[47:32], pitch_angle[63:48], roll_angle[79:64]
    input  wire logic [79:0] s_axis_tdata,
    output wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // heading[15:0]
    output wire logic [15:0] m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    import tcch_pkg::*;

    localparam int LAT = 2 * NSTEPS + 7;

    logic signed [15:0] dec_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    assign en = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg <= '0;
            vld_reg <= '0;
        end else begin
            if (cfg_we) dec_reg <= cfg_wdata;
            if (en) vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 0: reduce angles and fold into [-90,90]
    function automatic rot_t seed(input logic signed [15:0] a);
        rot_t r;
        logic signed [17:0] m;
        // a 16-bit angle never reaches a full turn, one add brings it into [0,360)
        m = 18'(a);
        if (m < 0) m = m + 18'sd36000;
        r.flip = 1'b0;
        if (m > 18'sd27000) m = m - 18'sd36000;
        else if (m > 18'sd9000) begin
            m = m - 18'sd18000;
            r.flip = 1'b1;
        end
        r.x = CORDIC_START;
        r.y = '0;
        r.z = ANG_W'(m) <<< 16;
        return r;
    endfunction

    logic signed [15:0] mx0, my0, mz0;
    rot_t pa [0:NSTEPS];
    rot_t ra [0:NSTEPS];
    logic signed [15:0] mx_d [0:NSTEPS];
    logic signed [15:0] my_d [0:NSTEPS];
    logic signed [15:0] mz_d [0:NSTEPS];
    logic signed [15:0] dc_d [0:NSTEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            pa[0] <= seed(s_axis_tdata[63:48]);
            ra[0] <= seed(s_axis_tdata[79:64]);
            mx_d[0] <= s_axis_tdata[15:0];
            my_d[0] <= s_axis_tdata[31:16];
            mz_d[0] <= s_axis_tdata[47:32];
            dc_d[0] <= dec_reg;
            for (int k = 0; k < NSTEPS; k++) begin
                mx_d[k+1] <= mx_d[k];
                my_d[k+1] <= my_d[k];
                mz_d[k+1] <= mz_d[k];
                dc_d[k+1] <= dc_d[k];
            end
        end
    end
    assign mx0 = mx_d[NSTEPS];
    assign my0 = my_d[NSTEPS];
    assign mz0 = mz_d[NSTEPS];

    for (genvar g = 0; g < NSTEPS; g++) begin : g_rot
        tcch_rot_cell u_cell (
            .aclk(aclk), .en(en), .idx(5'(g)),
            .a_in(pa[g]), .b_in(ra[g]), .a_out(pa[g+1]), .b_out(ra[g+1])
        );
    end

    // apply quadrant flip
    cs_t cp, sp, cr, sr;
    always_comb begin
        cp = pa[NSTEPS].flip ? -pa[NSTEPS].x : pa[NSTEPS].x;
        sp = pa[NSTEPS].flip ? -pa[NSTEPS].y : pa[NSTEPS].y;
        cr = ra[NSTEPS].flip ? -ra[NSTEPS].x : ra[NSTEPS].x;
        sr = ra[NSTEPS].flip ? -ra[NSTEPS].y : ra[NSTEPS].y;
    end

    // stage A: trig products, Q30 * Q30 -> Q30
    cs_t srsp_reg, crsp_reg, cp_a, cr_a, sr_a;
    logic signed [15:0] mx_a, my_a, mz_a, dc_a;
    logic signed [2*CS_W-1:0] p1, p2;
    assign p1 = (2*CS_W)'(sr) * (2*CS_W)'(sp);
    assign p2 = (2*CS_W)'(cr) * (2*CS_W)'(sp);
    always_ff @(posedge aclk) begin
        if (en) begin
            srsp_reg <= CS_W'(p1 >>> 30);
            crsp_reg <= CS_W'(p2 >>> 30);
            cp_a <= cp; cr_a <= cr; sr_a <= sr;
            mx_a <= mx0; my_a <= my0; mz_a <= mz0; dc_a <= dc_d[NSTEPS];
        end
    end

    // stage B: field products
    vec_t t1, t2, t3, t4, t5;
    logic signed [15:0] dc_b;
    always_ff @(posedge aclk) begin
        if (en) begin
            t1 <= VEC_W'(mx_a) * VEC_W'(cp_a);
            t2 <= VEC_W'(my_a) * VEC_W'(srsp_reg);
            t3 <= VEC_W'(mz_a) * VEC_W'(crsp_reg);
            t4 <= VEC_W'(my_a) * VEC_W'(cr_a);
            t5 <= VEC_W'(mz_a) * VEC_W'(sr_a);
            dc_b <= dc_a;
        end
    end

    // stage C: sums
    vec_t xh, yh;
    logic signed [15:0] dc_c;
    always_ff @(posedge aclk) begin
        if (en) begin
            xh <= t1 - t2 + t3;
            yh <= t4 + t5;
            dc_c <= dc_b;
        end
    end

    // stage D: half-plane fold
    vecs_t va [0:NSTEPS];
    ang_t da [0:NSTEPS];
    always_ff @(posedge aclk) begin
        if (en) begin
            va[0].zero <= (xh == '0) && (yh == '0);
            va[0].x <= xh[VEC_W-1] ? -xh : xh;
            va[0].y <= xh[VEC_W-1] ? -yh : yh;
            va[0].z <= xh[VEC_W-1] ? HALF_TURN_ANG : '0;
            da[0] <= ANG_W'(dc_c) <<< 16;
        end
    end

    for (genvar g = 0; g < NSTEPS; g++) begin : g_vec
        tcch_vec_cell u_cell (
            .aclk(aclk), .en(en), .idx(5'(g)),
            .v_in(va[g]), .dec_in(da[g]), .v_out(va[g+1]), .dec_out(da[g+1])
        );
    end

    // stage E: subtract declination, then wrap into [0,360) (range stays within two turns)
    localparam logic signed [33:0] TURN = 34'sd2359296000;
    logic signed [33:0] a_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= (va[NSTEPS].zero ? 34'sd0 : 34'(va[NSTEPS].z)) - 34'(da[NSTEPS]);
        end
    end

    logic signed [33:0] aw;
    always_comb begin
        aw = a_reg;
        if (aw >= TURN) aw = aw - TURN;
        else if (aw < 0) aw = aw + TURN;
        if (aw >= TURN) aw = aw - TURN;
        else if (aw < 0) aw = aw + TURN;
    end

    // stage F: round and wrap 360 to 0
    logic [33:0] hr;
    logic [15:0] h_reg;
    assign hr = 34'(aw + 34'sd32768) >> 16;
    always_ff @(posedge aclk) begin
        if (en) h_reg <= (hr[15:0] >= 16'd36000) ? hr[15:0] - 16'd36000 : hr[15:0];
    end

    assign m_axis_tdata = h_reg;
endmodule
`default_nettype wire

// File: sv/tcch_checker.sv
`default_nettype none
module tcch_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata < 16'd36000) else $error("heading out of range");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result not held");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready) else $error("input stalled");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind tilt_compensated_compass_heading_top tcch_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
